/* rtl/core/tile_alpha_occupancy_map_assert.svh */
// assertion macros for the tile alpha occupancy map
`ifndef TILE_ALPHA_OCCUPANCY_MAP_ASSERT_SVH
`define TILE_ALPHA_OCCUPANCY_MAP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TAO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tao assertion failed");
`define TAO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tao assertion failed");
`else
`define TAO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TAO_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/tao_pkg.sv */
`default_nettype none
package tao_pkg;

    localparam int SLOT_W     = 6;
    localparam int FLAG_DEPTH = 64;
    localparam int TOTAL_W    = 13;
    localparam int CFG_W      = 11;
    localparam int TEXEL_W    = 32;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FORMAT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_OPAQUE = 2'd0,
        FMT_A8     = 2'd1,
        FMT_RGBA   = 2'd2
    } t_fmt;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd1024;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              nz;
        logic              cell_end;
        logic              frame_end;
        logic [SLOT_W-1:0] col;
        logic [SLOT_W-1:0] row;
        logic              fwd_hit;
        logic              fwd_val;
    } t_s1;

endpackage
`default_nettype wire

/* rtl/core/tile_alpha_occupancy_map.sv */
// output: a texel that closes a cell raises o_valid with its word when it leaves stage 1
// throughput: one texel per cycle while o_stall is low; the per-column flag memory is read on
//   acceptance and written back from stage 1, with a bypass when consecutive texels share a column
// reset: synchronous, active low; registers go to 1024 x 1024 A8, position and counts
//   clear, flag memory valid bits clear at once; a width, height or format write restarts the frame
`default_nettype none
`include "tile_alpha_occupancy_map_assert.svh"
module tile_alpha_occupancy_map
    import tao_pkg::*;
#(
    parameter int TILE_PX    = 16,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [TEXEL_W-1:0] i_texel,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [SLOT_W-1:0]       o_cell_column,
    output logic [SLOT_W-1:0]       o_cell_row,
    output logic                    o_occupied,
    output logic [TOTAL_W-1:0]      o_occupied_total,
    output logic                    o_frame_done,
    output logic                    o_all_empty,
    output logic                    o_all_full
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PXW   = XW + 1;
    localparam int PYW   = YW + 1;
    localparam int CMPXW = (PXW > CFG_W) ? PXW : CFG_W;
    localparam int CMPYW = (PYW > CFG_W) ? PYW : CFG_W;
    localparam int CXW   = (TILE_PX > 1) ? $clog2(TILE_PX) : 1;
    localparam int NCOL  = (MAX_WIDTH + TILE_PX - 1) / TILE_PX;
    localparam int NROW  = (MAX_HEIGHT + TILE_PX - 1) / TILE_PX;
    localparam int COLW  = (NCOL > 1) ? $clog2(NCOL) : 1;
    localparam int ROWW  = (NROW > 1) ? $clog2(NROW) : 1;
    localparam int NCELL = NCOL * NROW;
    localparam int CW    = $clog2(NCELL + 1);

    // configuration
    logic [PXW-1:0] r_width;
    logic [PYW-1:0] r_height;
    logic [1:0]     r_format;
    logic [PXW-1:0] n_width;
    logic [PYW-1:0] n_height;
    logic [CMPXW-1:0] cfg_wx;
    logic [CMPYW-1:0] cfg_hx;
    logic cfg_wr;
    logic cfg_hit;

    // position
    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [CXW-1:0]  r_cx;
    logic [CXW-1:0]  r_cy;
    logic [COLW-1:0] r_col;
    logic [ROWW-1:0] r_row;

    // counts
    logic [CW-1:0] r_occ_cnt;
    logic [CW-1:0] r_cell_cnt;
    logic [CW-1:0] occ_sum;
    logic [CW-1:0] cell_sum;

    // flag memory
    logic [FLAG_DEPTH-1:0] r_vbits;
    logic                  ram_rdata;
    logic                  ram_wdata;

    t_s1  r_s1;
    t_s1  n_s1;
    logic r_s1_vld;

    logic acc;
    logic s1_fire;
    logic last_x;
    logic last_y;
    logic cx_end;
    logic cy_end;
    logic nz;
    logic [COLW+SLOT_W-1:0]    col_ext;
    logic [ROWW+SLOT_W-1:0]    row_ext;
    logic [CW+TOTAL_W-1:0]     total_ext;
    logic flag_old;
    logic flag_new;

    assign cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign cfg_hit = cfg_wr && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT
                                || i_cfg_index == CFG_FORMAT);
    assign o_cfg_ready = !r_s1_vld;

    always_comb begin
        cfg_wx = CMPXW'(i_cfg_data);
        cfg_hx = CMPYW'(i_cfg_data);
        if (cfg_wx == '0) begin
            n_width = PXW'(1);
        end else if (cfg_wx > CMPXW'(MAX_WIDTH)) begin
            n_width = PXW'(MAX_WIDTH);
        end else begin
            n_width = cfg_wx[PXW-1:0];
        end
        if (cfg_hx == '0) begin
            n_height = PYW'(1);
        end else if (cfg_hx > CMPYW'(MAX_HEIGHT)) begin
            n_height = PYW'(MAX_HEIGHT);
        end else begin
            n_height = cfg_hx[PYW-1:0];
        end
    end

    // stage 0: position and alpha test
    always_comb begin
        case (r_format)
            FMT_A8:   nz = (i_texel[7:0] != 8'd0);
            FMT_RGBA: nz = (i_texel[31:24] != 8'd0);
            default:  nz = 1'b1;
        endcase
    end

    assign last_x  = ({1'b0, r_x} + PXW'(1)) == r_width;
    assign last_y  = ({1'b0, r_y} + PYW'(1)) == r_height;
    assign cx_end  = (r_cx == CXW'(TILE_PX - 1));
    assign cy_end  = (r_cy == CXW'(TILE_PX - 1));
    assign col_ext = {{SLOT_W{1'b0}}, r_col};
    assign row_ext = {{SLOT_W{1'b0}}, r_row};

    assign s1_fire = r_s1_vld && (!r_s1.cell_end || !o_valid || !i_stall);
    assign o_stall = (r_s1_vld && !s1_fire) || cfg_wr;
    assign acc     = i_valid && !o_stall;

    // stage 1: read-modify-write of the column flag
    assign flag_old  = r_s1.fwd_hit ? r_s1.fwd_val : (r_vbits[r_s1.slot] && ram_rdata);
    assign flag_new  = flag_old || r_s1.nz;
    assign ram_wdata = r_s1.cell_end ? 1'b0 : flag_new;
    assign occ_sum   = r_occ_cnt + CW'(flag_new);
    assign cell_sum  = r_cell_cnt + CW'(1);
    assign total_ext = {{TOTAL_W{1'b0}}, occ_sum};

    always_comb begin
        n_s1.slot      = col_ext[SLOT_W-1:0];
        n_s1.nz        = nz;
        n_s1.cell_end  = (cx_end || last_x) && (cy_end || last_y);
        n_s1.frame_end = last_x && last_y;
        n_s1.col       = col_ext[SLOT_W-1:0];
        n_s1.row       = row_ext[SLOT_W-1:0];
        n_s1.fwd_hit   = s1_fire && (r_s1.slot == col_ext[SLOT_W-1:0]);
        n_s1.fwd_val   = ram_wdata;
    end

    tao_ram #(
        .WIDTH (1),
        .DEPTH (FLAG_DEPTH)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1.slot),
        .i_wdata (ram_wdata),
        .i_re    (acc),
        .i_raddr (col_ext[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= PXW'(CMPXW'(RST_WIDTH) > CMPXW'(MAX_WIDTH) ? CMPXW'(MAX_WIDTH)
                                                                     : CMPXW'(RST_WIDTH));
            r_height   <= PYW'(CMPYW'(RST_HEIGHT) > CMPYW'(MAX_HEIGHT) ? CMPYW'(MAX_HEIGHT)
                                                                       : CMPYW'(RST_HEIGHT));
            r_format   <= FMT_A8;
            r_x        <= '0;
            r_y        <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_occ_cnt  <= '0;
            r_cell_cnt <= '0;
            r_vbits    <= '0;
            r_s1_vld   <= 1'b0;
            o_valid    <= 1'b0;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= n_width;
                CFG_HEIGHT: r_height <= n_height;
                CFG_FORMAT: r_format <= i_cfg_data[1:0];
                default:    r_format <= r_format;
            endcase
            r_x        <= '0;
            r_y        <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_occ_cnt  <= '0;
            r_cell_cnt <= '0;
            r_vbits    <= '0;
            if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end else begin
            if (acc) begin
                if (last_x) begin
                    r_x   <= '0;
                    r_cx  <= '0;
                    r_col <= '0;
                    if (last_y) begin
                        r_y   <= '0;
                        r_cy  <= '0;
                        r_row <= '0;
                    end else begin
                        r_y   <= r_y + YW'(1);
                        r_cy  <= cy_end ? '0 : r_cy + CXW'(1);
                        r_row <= cy_end ? r_row + ROWW'(1) : r_row;
                    end
                end else begin
                    r_x   <= r_x + XW'(1);
                    r_cx  <= cx_end ? '0 : r_cx + CXW'(1);
                    r_col <= cx_end ? r_col + COLW'(1) : r_col;
                end
            end
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_vbits[r_s1.slot] <= 1'b1;
            end
            if (s1_fire && r_s1.cell_end) begin
                r_occ_cnt  <= r_s1.frame_end ? '0 : occ_sum;
                r_cell_cnt <= r_s1.frame_end ? '0 : cell_sum;
                o_valid    <= 1'b1;
            end else if (!i_stall) begin
                o_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
        if (s1_fire && r_s1.cell_end) begin
            o_cell_column    <= r_s1.col;
            o_cell_row       <= r_s1.row;
            o_occupied       <= flag_new;
            o_occupied_total <= total_ext[TOTAL_W-1:0];
            o_frame_done     <= r_s1.frame_end;
            o_all_empty      <= r_s1.frame_end && (occ_sum == '0);
            o_all_full       <= r_s1.frame_end && (occ_sum == cell_sum);
        end
    end

    `TAO_ASSERT_IMP(a_flags_need_done, i_clk, i_rst_n,
                    o_valid && (o_all_empty || o_all_full), o_frame_done)
    `TAO_ASSERT_IMP(a_full_not_empty, i_clk, i_rst_n, o_valid && o_all_full, !o_all_empty)
    `TAO_ASSERT_NXT(a_frame_restart, i_clk, i_rst_n,
                    s1_fire && r_s1.cell_end && r_s1.frame_end,
                    r_occ_cnt == '0 && r_cell_cnt == '0)
    `TAO_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_occ_cnt <= r_cell_cnt)
    `TAO_ASSERT_NXT(a_bypass_taken, i_clk, i_rst_n,
                    acc && s1_fire && (r_s1.slot == col_ext[SLOT_W-1:0]), r_s1.fwd_hit)

endmodule
`default_nettype wire

/* rtl/core/tao_ram.sv */
`default_nettype none
module tao_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* tb/tile_alpha_occupancy_map_tb.sv */
`default_nettype none
module tile_alpha_occupancy_map_tb;
    import tao_pkg::*;

    localparam int CELL          = 16;
    localparam int MAX_DIM       = 1024;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_TEXELS = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]  col;
        logic [SLOT_W-1:0]  row;
        logic               occ;
        logic [TOTAL_W-1:0] total;
        logic               done;
        logic               empty;
        logic               full;
    } t_cell_word;

    typedef enum logic {ROW_REG, ROW_TEXEL} t_row_kind;

    typedef enum logic [1:0] {FILL_EMPTY, FILL_FULL, FILL_SPARSE, FILL_RAW} t_fill;

    typedef struct {
        t_row_kind          kind;
        logic [1:0]         idx;
        logic [TEXEL_W-1:0] data;
        bit                 typed;
        t_cell_word         word;
    } t_dir_row;

    localparam t_cell_word ONE_EMPTY = '{col: '0, row: '0, occ: 1'b0, total: '0,
                                         done: 1'b1, empty: 1'b1, full: 1'b0};
    localparam t_cell_word ONE_FULL  = '{col: '0, row: '0, occ: 1'b1, total: 13'd1,
                                         done: 1'b1, empty: 1'b0, full: 1'b1};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [TEXEL_W-1:0] i_texel;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_valid;
    logic               i_stall;
    logic [SLOT_W-1:0]  o_cell_column;
    logic [SLOT_W-1:0]  o_cell_row;
    logic               o_occupied;
    logic [TOTAL_W-1:0] o_occupied_total;
    logic               o_frame_done;
    logic               o_all_empty;
    logic               o_all_full;

    tile_alpha_occupancy_map DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_texel          (i_texel),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cell_column    (o_cell_column),
        .o_cell_row       (o_cell_row),
        .o_occupied       (o_occupied),
        .o_occupied_total (o_occupied_total),
        .o_frame_done     (o_frame_done),
        .o_all_empty      (o_all_empty),
        .o_all_full       (o_all_full)
    );

    // occupancy map state
    bit               band_flags [FLAG_DEPTH];
    int               pos_x;
    int               pos_y;
    int               occ_count;
    logic [CFG_W-1:0] reg_width;
    logic [CFG_W-1:0] reg_height;
    logic [1:0]       reg_format;

    t_cell_word cell_words_q [$];
    t_dir_row   dir_rows [$];
    int         mismatches;
    int         send_gap_max;
    int         stall_max;
    bit         long_hold;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void restart_map();
        foreach (band_flags[i]) band_flags[i] = 1'b0;
        pos_x     = 0;
        pos_y     = 0;
        occ_count = 0;
    endfunction

    function automatic int clip_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_WIDTH:  reg_width  = data;
            CFG_HEIGHT: reg_height = data;
            CFG_FORMAT: reg_format = data[1:0];
            default:    return;
        endcase
        restart_map();
    endfunction

    function automatic bit map_texel(logic [TEXEL_W-1:0] t, output t_cell_word word);
        int w, h, x, y, col, row, slot, cells;
        bit nz, last_x, last_y, cell_end, frame_end, occ;
        w = clip_dim(reg_width);
        h = clip_dim(reg_height);
        x = (pos_x >= w) ? 0 : pos_x;
        y = (pos_y >= h) ? 0 : pos_y;
        if (reg_format == FMT_A8) begin
            nz = (t[7:0] != 0);
        end else if (reg_format == FMT_RGBA) begin
            nz = (t[31:24] != 0);
        end else begin
            nz = 1'b1;
        end
        col  = x / CELL;
        row  = y / CELL;
        slot = col % FLAG_DEPTH;
        if (nz) band_flags[slot] = 1'b1;
        last_x    = (x + 1 == w);
        last_y    = (y + 1 == h);
        cell_end  = (((x + 1) % CELL == 0) || last_x) && (((y + 1) % CELL == 0) || last_y);
        frame_end = last_x && last_y;
        if (last_x) begin
            pos_x = 0;
            pos_y = last_y ? 0 : y + 1;
        end else begin
            pos_x = x + 1;
            pos_y = y;
        end
        word = '0;
        if (!cell_end) return 1'b0;
        occ = band_flags[slot];
        band_flags[slot] = 1'b0;
        occ_count += occ;
        cells = ((w + CELL - 1) / CELL) * ((h + CELL - 1) / CELL);
        word.col   = SLOT_W'(col);
        word.row   = SLOT_W'(row);
        word.occ   = occ;
        word.total = TOTAL_W'(occ_count);
        word.done  = frame_end;
        word.empty = frame_end && (occ_count == 0);
        word.full  = frame_end && (occ_count == cells);
        if (frame_end) restart_map();
        return 1'b1;
    endfunction

    function automatic logic [TEXEL_W-1:0] gen_texel(t_fill fill);
        logic [TEXEL_W-1:0] t;
        t = $urandom;
        case (fill)
            FILL_EMPTY: begin
                t[7:0]   = '0;
                t[31:24] = '0;
            end
            FILL_FULL: begin
                if (t[7:0] == 0) t[0] = 1'b1;
                if (t[31:24] == 0) t[24] = 1'b1;
            end
            FILL_SPARSE: begin
                if ($urandom_range(0, 15) != 0) begin
                    t[7:0]   = '0;
                    t[31:24] = '0;
                end
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic t_dir_row reg_row(logic [1:0] idx, logic [CFG_W-1:0] data);
        return '{kind: ROW_REG, idx: idx, data: TEXEL_W'(data), typed: 1'b0, word: '0};
    endfunction

    function automatic t_dir_row texel_row(logic [TEXEL_W-1:0] t);
        return '{kind: ROW_TEXEL, idx: '0, data: t, typed: 1'b0, word: '0};
    endfunction

    function automatic t_dir_row check_row(logic [TEXEL_W-1:0] t, t_cell_word word);
        return '{kind: ROW_TEXEL, idx: '0, data: t, typed: 1'b1, word: word};
    endfunction

    task automatic send_texel(logic [TEXEL_W-1:0] t, bit typed, t_cell_word typed_word);
        int         gap;
        bit         has;
        t_cell_word word;
        gap = $urandom_range(0, send_gap_max);
        repeat (gap) begin
            @(negedge i_clk) i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_texel <= t;
        do @(posedge i_clk); while (o_stall);
        has = map_texel(t, word);
        if (has) cell_words_q.push_back(typed ? typed_word : word);
    endtask

    task automatic send_run(int n, t_fill fill);
        repeat (n) send_texel(gen_texel(fill), 1'b0, '0);
    endtask

    // let every expected word drain, plus the pipeline depth
    task automatic settle();
        @(negedge i_clk) i_valid <= 1'b0;
        while (cell_words_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, logic [1:0] fmt);
        write_reg(CFG_WIDTH, CFG_W'(w));
        write_reg(CFG_HEIGHT, CFG_W'(h));
        write_reg(CFG_FORMAT, CFG_W'(fmt));
    endtask

    // result side
    initial begin
        int         n;
        t_cell_word got;
        t_cell_word want;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold) begin
                n = HOLD_CYCLES;
                long_hold = 1'b0;
            end else begin
                n = $urandom_range(0, stall_max);
            end
            repeat (n) begin
                @(negedge i_clk) i_stall <= 1'b1;
                @(posedge i_clk);
            end
            @(negedge i_clk) i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got = '{o_cell_column, o_cell_row, o_occupied, o_occupied_total,
                    o_frame_done, o_all_empty, o_all_full};
            if (cell_words_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: col %0d row %0d occ %0b total %0d",
                             got.col, got.row, got.occ, got.total);
            end else begin
                want = cell_words_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("expected col %0d row %0d occ %0b total %0d done %0b %0b %0b",
                                 want.col, want.row, want.occ, want.total,
                                 want.done, want.empty, want.full);
                        $display("actual   col %0d row %0d occ %0b total %0d done %0b %0b %0b",
                                 got.col, got.row, got.occ, got.total,
                                 got.done, got.empty, got.full);
                    end
                end
            end
        end
    end

    // texel and register side
    initial begin
        int dim_marks [7] = '{1, 15, 16, 17, 31, 32, 33};
        int random_texels;
        int w, h, frames, part;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_texel      = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        send_gap_max = 7;
        stall_max    = 7;
        long_hold    = 1'b0;
        mismatches   = 0;
        reg_width    = RST_WIDTH;
        reg_height   = RST_HEIGHT;
        reg_format   = FMT_A8;
        restart_map();

        // texels under the reset setting, none closes a cell
        repeat (3) dir_rows.push_back(texel_row(32'h1234_5678));
        dir_rows.push_back(reg_row(CFG_WIDTH, 11'd1));
        dir_rows.push_back(reg_row(CFG_HEIGHT, 11'd1));
        dir_rows.push_back(reg_row(CFG_FORMAT, CFG_W'(FMT_A8)));
        dir_rows.push_back(check_row(32'h0000_0000, ONE_EMPTY));
        dir_rows.push_back(check_row(32'h0000_00FF, ONE_FULL));
        dir_rows.push_back(check_row(32'hFFFF_FF00, ONE_EMPTY));
        dir_rows.push_back(reg_row(CFG_FORMAT, CFG_W'(FMT_RGBA)));
        dir_rows.push_back(check_row(32'hFF00_0000, ONE_FULL));
        dir_rows.push_back(check_row(32'h00FF_FFFF, ONE_EMPTY));
        dir_rows.push_back(reg_row(CFG_FORMAT, CFG_W'(FMT_OPAQUE)));
        dir_rows.push_back(check_row(32'h0000_0000, ONE_FULL));
        // unused format code acts as opaque
        dir_rows.push_back(reg_row(CFG_FORMAT, 11'd3));
        dir_rows.push_back(check_row(32'h0000_0000, ONE_FULL));
        // write to an unused index changes nothing
        dir_rows.push_back(reg_row(CFG_NONE, 11'h7FF));
        dir_rows.push_back(check_row(32'h0000_0000, ONE_FULL));
        dir_rows.push_back(reg_row(CFG_WIDTH, 11'd2));
        dir_rows.push_back(reg_row(CFG_HEIGHT, 11'd2));
        dir_rows.push_back(reg_row(CFG_FORMAT, CFG_W'(FMT_A8)));
        dir_rows.push_back(texel_row(32'h0000_0000));
        dir_rows.push_back(texel_row(32'h0000_FF00));
        dir_rows.push_back(texel_row(32'hFFFF_FF00));
        dir_rows.push_back(check_row(32'h0000_0080, ONE_FULL));
        // zero size counts as one
        dir_rows.push_back(reg_row(CFG_WIDTH, 11'd0));
        dir_rows.push_back(reg_row(CFG_HEIGHT, 11'd0));
        dir_rows.push_back(check_row(32'h0000_0001, ONE_FULL));
        // a register write mid frame drops the partial cell
        dir_rows.push_back(reg_row(CFG_WIDTH, 11'd2));
        dir_rows.push_back(reg_row(CFG_HEIGHT, 11'd2));
        dir_rows.push_back(texel_row(32'h0000_00FF));
        dir_rows.push_back(reg_row(CFG_HEIGHT, 11'd1));
        dir_rows.push_back(texel_row(32'h0000_0000));
        dir_rows.push_back(check_row(32'h0000_0000, ONE_EMPTY));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG) begin
                settle();
                write_reg(dir_rows[k].idx, CFG_W'(dir_rows[k].data));
            end else begin
                send_texel(dir_rows[k].data, dir_rows[k].typed, dir_rows[k].word);
            end
        end

        random_texels = 0;
        while (random_texels < RANDOM_TEXELS) begin
            settle();
            if ($urandom_range(0, 2) == 0) begin
                w = dim_marks[$urandom_range(0, 6)];
                h = dim_marks[$urandom_range(0, 6)];
                if (w * h > 300) h = $urandom_range(1, 300 / w);
            end else begin
                w = $urandom_range(1, 48);
                h = $urandom_range(1, 240 / w);
            end
            set_frame(w, h, 2'($urandom_range(0, 3)));
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            stall_max    = ($urandom_range(0, 3) == 0) ? 0 : 7;
            frames = $urandom_range(1, 3);
            repeat (frames) send_run(w * h, t_fill'($urandom_range(0, 3)));
            random_texels += frames * w * h;
            if ($urandom_range(0, 3) == 0 && w * h > 1) begin
                part = $urandom_range(1, w * h - 1);
                send_run(part, FILL_RAW);
                random_texels += part;
            end
        end

        // one word per texel while the result side holds off
        settle();
        set_frame(1, 1, FMT_OPAQUE);
        send_gap_max = 0;
        stall_max    = 7;
        long_hold    = 1'b1;
        send_run(40, FILL_RAW);

        // oversize values saturate, start of a wide and of a tall frame
        settle();
        send_gap_max = 3;
        set_frame(2047, 1, FMT_A8);
        send_run(48, FILL_FULL);
        settle();
        set_frame(0, 2047, FMT_RGBA);
        send_run(48, FILL_SPARSE);

        settle();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/tao_pkg.sv
rtl/core/tao_ram.sv
rtl/core/tile_alpha_occupancy_map.sv
tb/tile_alpha_occupancy_map_tb.sv
